[sv/hbwq_pkg.sv]
package hbwq_pkg;
    localparam int BUCKETS_DEF  = 64;
    localparam int ENTRIES_DEF  = 256;
    localparam int TAG_BITS_DEF = 16;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int BIDX_W   = 6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_WRITE = 2'd2
    } t_state;
endpackage

[sv/hbwq_if.sv]
interface hbwq_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic        is_hashed;
    logic [31:0] hash_key;
    logic [15:0] work_tag;
    modport source(output valid, command, is_hashed, hash_key, work_tag, input ready);
    modport sink(input valid, command, is_hashed, hash_key, work_tag, output ready);
endinterface

interface hbwq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] tag_out;
    logic        from_bucket;
    logic [5:0]  bucket_index;
    modport source(output valid, status, tag_out, from_bucket, bucket_index, input ready);
    modport sink(input valid, status, tag_out, from_bucket, bucket_index, output ready);
endinterface

[sv/hbwq_front.sv]
// Input stage: registers one command and works out its list number.
module hbwq_front
    import hbwq_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int LW      = $clog2(BUCKETS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hbwq_in_if.sink         i_in,
    input  logic            i_take,
    output logic            o_valid,
    output logic            o_cmd,
    output logic            o_hashed,
    output logic [LW-1:0]   o_list,
    output logic [TAG_W-1:0] o_tag
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    logic r_valid;
    logic r_cmd, r_hashed;
    logic [LW-1:0] r_list;
    logic [TAG_W-1:0] r_tag;
    logic [LW-1:0] n_list;

    // key mod BUCKETS: a mask for a power of two, else an exact reciprocal multiply
    generate
        if ((1 << BW) == BUCKETS) begin : g_mask
            always_comb begin
                if (i_in.is_hashed) begin
                    n_list = LW'(i_in.hash_key[BW-1:0]);
                end else begin
                    n_list = LW'(BUCKETS);
                end
            end
        end else begin : g_recip
            localparam logic [32:0] RECIP = 33'(((64'd1 << (KEY_W + BW))
                + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
            logic [KEY_W+32:0] prod;
            logic [KEY_W-1:0]  quot;
            logic [KEY_W-1:0]  rem;
            always_comb begin
                prod = {33'd0, i_in.hash_key} * {32'd0, RECIP};
                quot = KEY_W'(prod >> (KEY_W + BW));
                rem  = i_in.hash_key - quot * KEY_W'(BUCKETS);
                if (i_in.is_hashed) begin
                    n_list = LW'(rem);
                end else begin
                    n_list = LW'(BUCKETS);
                end
            end
        end
    endgenerate

    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
        if (i_in.valid && i_in.ready) begin
            r_cmd    <= i_in.command;
            r_hashed <= i_in.is_hashed;
            r_list   <= n_list;
            r_tag    <= i_in.work_tag;
        end
    end

    assign o_valid  = r_valid;
    assign o_cmd    = r_cmd;
    assign o_hashed = r_hashed;
    assign o_list   = r_list;
    assign o_tag    = r_tag;
endmodule

[sv/hbwq_back.sv]
// Linked-list engine: issue, read and write states per command.
module hbwq_back
    import hbwq_pkg::*;
#(
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int LW       = $clog2(BUCKETS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_cmd,
    input  logic             i_hashed,
    input  logic [LW-1:0]    i_list,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_take,
    hbwq_out_if.source       o_out
);
    localparam int EW = $clog2(ENTRIES);
    localparam int FW = EW + 1;
    localparam int NL = BUCKETS + 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int TS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    // links are one bit wider so a freed entry can carry the end-of-free-list mark
    logic [TS-1:0] m_tag [ENTRIES];
    logic [FW-1:0] m_link[ENTRIES];
    logic [EW-1:0] m_head[NL];
    logic [EW-1:0] m_tail[NL];

    t_state r_state, n_state;
    logic [BUCKETS-1:0] r_bne;
    logic r_mne;
    logic [FW-1:0] r_fresh, r_free;
    logic [LW-1:0] r_l;
    logic [EW-1:0] r_e;
    logic r_busy;
    logic r_use_free;
    logic [EW-1:0] r_head, r_tail;
    logic [FW-1:0] r_link;
    logic [TS-1:0] r_rtag;

    logic r_ov;
    logic [1:0] r_st;
    logic [TAG_W-1:0] r_otag;
    logic r_ofb;
    logic [BIDX_W-1:0] r_obi;

    // lowest set bucket
    logic [LW-1:0] pick;
    always_comb begin
        pick = LW'(BUCKETS);
        for (int b = BUCKETS - 1; b >= 0; b--) begin
            if (r_bne[b]) pick = LW'(b);
        end
    end

    logic out_free;
    assign out_free = !r_ov || o_out.ready;
    logic [LW-1:0] lsel;
    assign lsel = (i_cmd == CMD_DEQ) ? pick : i_list;
    logic lbusy;
    assign lbusy = (lsel == LW'(BUCKETS)) ? r_mne : r_bne[lsel[BW-1:0]];
    logic has_free, has_fresh;
    assign has_free  = r_free < FW'(ENTRIES);
    assign has_fresh = r_fresh < FW'(ENTRIES);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && out_free) n_state = S_READ;
            S_READ:  n_state = S_WRITE;
            S_WRITE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_take = (r_state == S_WRITE);
    end

    logic [EW-1:0] alloc;
    assign alloc = has_free ? r_free[EW-1:0] : r_fresh[EW-1:0];
    logic [BIDX_W-1:0] lbi;
    assign lbi = BIDX_W'(r_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bne   <= '0;
            r_mne   <= 1'b0;
            r_fresh <= '0;
            r_free  <= FW'(ENTRIES);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && out_free) begin
                    r_l    <= lsel;
                    r_busy <= lbusy;
                    r_use_free <= has_free;
                    r_e    <= alloc;
                    r_head <= m_head[lsel];
                    r_tail <= m_tail[lsel];
                    if (i_cmd == CMD_ENQ) r_link <= m_link[r_free[EW-1:0]];
                end
                S_READ: begin
                    if (i_cmd != CMD_ENQ) r_link <= m_link[r_head];
                    r_rtag <= m_tag[r_head];
                end
                S_WRITE: begin
                    r_ov <= 1'b1;
                    if (i_cmd == CMD_ENQ) begin
                        r_otag <= '0;
                        r_ofb  <= 1'b0;
                        r_obi  <= i_hashed ? lbi : '0;
                        if (!r_use_free && !has_fresh) begin
                            r_st <= ST_FULL;
                        end else begin
                            r_st <= ST_OK;
                            if (r_use_free) begin
                                r_free <= (r_link > FW'(ENTRIES)) ? FW'(ENTRIES) : r_link;
                            end else begin
                                r_fresh <= r_fresh + 1'b1;
                            end
                            m_tag[r_e] <= i_tag[TS-1:0];
                            if (r_busy) m_link[r_tail] <= {1'b0, r_e};
                            else m_head[r_l] <= r_e;
                            m_tail[r_l] <= r_e;
                            if (r_l == LW'(BUCKETS)) r_mne <= 1'b1;
                            else r_bne[r_l[BW-1:0]] <= 1'b1;
                        end
                    end else if (!r_busy) begin
                        r_st   <= ST_EMPTY;
                        r_otag <= '0;
                        r_ofb  <= 1'b0;
                        r_obi  <= '0;
                    end else begin
                        if (r_head == r_tail) begin
                            if (r_l == LW'(BUCKETS)) r_mne <= 1'b0;
                            else r_bne[r_l[BW-1:0]] <= 1'b0;
                        end else begin
                            m_head[r_l] <= r_link[EW-1:0];
                        end
                        m_link[r_head] <= r_free;
                        r_free <= {1'b0, r_head};
                        r_st   <= ST_OK;
                        r_otag <= TAG_W'(r_rtag);
                        r_ofb  <= (r_l != LW'(BUCKETS));
                        r_obi  <= (r_l != LW'(BUCKETS)) ? lbi : '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.status = r_st;
    assign o_out.tag_out = r_otag;
    assign o_out.from_bucket = r_ofb;
    assign o_out.bucket_index = r_obi;
endmodule

[sv/hashed_bucket_work_queue.sv]
// Hashed bucket work queue. Each item is an enqueue (tag into bucket
// hash_key mod BUCKETS, or the main FIFO) or a dequeue (head of the lowest
// non-empty bucket, else main FIFO). An item runs through the list engine
// in order: issue with head/tail read, dependent link and tag read, list
// write. The engine takes no new item until the last one has been written,
// and the result sits in an output register. The input register takes the
// next item in the write cycle; a result that is not yet taken holds the
// engine in issue until the output register frees up.
// No clearing pass after reset: entries are handed out by a fresh count.
module hashed_bucket_work_queue
    import hbwq_pkg::*;
#(
    parameter int BUCKETS  = BUCKETS_DEF,
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hbwq_in_if.sink    i_in,
    hbwq_out_if.source o_out
);
    localparam int LW = $clog2(BUCKETS + 1);
    logic v, c, h, take;
    logic [LW-1:0] l;
    logic [TAG_W-1:0] t;

    hbwq_front #(.BUCKETS(BUCKETS), .LW(LW)) u_front (
        .i_clk, .i_rst_n, .i_in, .i_take(take),
        .o_valid(v), .o_cmd(c), .o_hashed(h), .o_list(l), .o_tag(t)
    );

    hbwq_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .TAG_BITS(TAG_BITS), .LW(LW))
    u_back (
        .i_clk, .i_rst_n, .i_valid(v), .i_cmd(c), .i_hashed(h), .i_list(l),
        .i_tag(t), .o_take(take), .o_out
    );
endmodule
